/* sv/tlmlp_pkg.sv */
// ============================================================================
// tlmlp_pkg - shared types, constants and fixed-point helpers
// Word/accumulator types, opcodes, stream field offsets and format
// conversions used by the two-layer perceptron datapath.
// ============================================================================
package tlmlp_pkg;

    localparam int WORD_W   = 16;
    localparam int ACC_W    = 32;
    localparam int OPCODE_W = 2;
    localparam int WADDR_W  = 8;

    // defaults for the top-level parameters
    localparam int DEF_HIDDEN_NEURONS = 16;
    localparam int DEF_FEATURE_COUNT  = 8;
    localparam int DEF_FRAC_BITS      = 8;
    localparam int DEF_ACC_FRAC_BITS  = 16;

    // slave-side tdata layout: 8 features, gate, weight address, weight value
    localparam int MAX_FEATURES  = 8;
    localparam int GATE_LSB      = MAX_FEATURES * WORD_W;
    localparam int WADDR_LSB     = GATE_LSB + WORD_W;
    localparam int WVALUE_LSB    = WADDR_LSB + WADDR_W;
    localparam int S_TDATA_W     = WVALUE_LSB + WORD_W;
    localparam int M_TDATA_W     = 2 * WORD_W;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SKIP  = 2'd0,
        OP_RUN   = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
        t_word              value;
    } t_wr_req;

    // word format -> accumulator format, wrapped to 32 bits
    function automatic t_acc to_acc(input t_word w, input int frac, input int acc);
        t_acc x;
        x = {{(ACC_W-WORD_W){w[WORD_W-1]}}, w};
        if (acc >= frac) begin
            return x <<< (acc - frac);
        end else begin
            return x >>> (frac - acc);
        end
    endfunction

    // accumulator format -> word format, floor then wrap to 16 bits
    function automatic t_word to_word(input t_acc a, input int frac, input int acc);
        t_acc t;
        if (acc >= frac) begin
            t = a >>> (acc - frac);
        end else begin
            t = a <<< (frac - acc);
        end
        return t[WORD_W-1:0];
    endfunction

    // full product floored back to the accumulator format, wrapped to 32 bits
    function automatic t_acc mac_term(input t_acc a, input t_acc b, input int acc);
        logic signed [2*ACC_W-1:0] p;
        p = a * b;
        p = p >>> acc;
        return p[ACC_W-1:0];
    endfunction

endpackage

/* sv/tlmlp_wstore.sv */
// ============================================================================
// tlmlp_wstore - weight and bias register file
// Holds layer-1 weights and biases, layer-2 weights and bias; one word
// written per request, everything cleared at reset.
// ============================================================================
module tlmlp_wstore #(
    parameter int HIDDEN_NEURONS = tlmlp_pkg::DEF_HIDDEN_NEURONS,
    parameter int FEATURE_COUNT  = tlmlp_pkg::DEF_FEATURE_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlmlp_pkg::t_wr_req i_wr,
    output tlmlp_pkg::t_word   o_w1 [HIDDEN_NEURONS][FEATURE_COUNT],
    output tlmlp_pkg::t_word   o_b1 [HIDDEN_NEURONS],
    output tlmlp_pkg::t_word   o_w2 [HIDDEN_NEURONS],
    output tlmlp_pkg::t_word   o_b2
);
    import tlmlp_pkg::*;

    localparam int L1B_BASE = HIDDEN_NEURONS * FEATURE_COUNT;
    localparam int L2W_BASE = L1B_BASE + HIDDEN_NEURONS;
    localparam int L2B_ADDR = L2W_BASE + HIDDEN_NEURONS;
    localparam int SPAN_W   = $clog2(L2B_ADDR + 1);
    localparam int AW       = (SPAN_W > WADDR_W) ? SPAN_W : WADDR_W;

    t_word r_w1 [HIDDEN_NEURONS][FEATURE_COUNT];
    t_word r_b1 [HIDDEN_NEURONS];
    t_word r_w2 [HIDDEN_NEURONS];
    t_word r_b2;

    logic [AW-1:0] w_addr;

    assign w_addr = AW'(i_wr.addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < HIDDEN_NEURONS; h++) begin
                for (int f = 0; f < FEATURE_COUNT; f++) begin
                    r_w1[h][f] <= '0;
                end
                r_b1[h] <= '0;
                r_w2[h] <= '0;
            end
            r_b2 <= '0;
        end else if (i_wr.en) begin
            // addresses past the layer-2 bias match nothing
            for (int h = 0; h < HIDDEN_NEURONS; h++) begin
                for (int f = 0; f < FEATURE_COUNT; f++) begin
                    if (w_addr == AW'(h * FEATURE_COUNT + f)) begin
                        r_w1[h][f] <= i_wr.value;
                    end
                end
                if (w_addr == AW'(L1B_BASE + h)) begin
                    r_b1[h] <= i_wr.value;
                end
                if (w_addr == AW'(L2W_BASE + h)) begin
                    r_w2[h] <= i_wr.value;
                end
            end
            if (w_addr == AW'(L2B_ADDR)) begin
                r_b2 <= i_wr.value;
            end
        end
    end

    assign o_w1 = r_w1;
    assign o_b1 = r_b1;
    assign o_w2 = r_w2;
    assign o_b2 = r_b2;

endmodule

/* sv/tlmlp_lane.sv */
// ============================================================================
// tlmlp_lane - one hidden neuron lane
// Feature products and bias into a registered adder tree, then ReLU and
// the neuron's layer-2 product.
// ============================================================================
module tlmlp_lane #(
    parameter int FEATURE_COUNT = tlmlp_pkg::DEF_FEATURE_COUNT,
    parameter int FRAC_BITS     = tlmlp_pkg::DEF_FRAC_BITS,
    parameter int ACC_FRAC_BITS = tlmlp_pkg::DEF_ACC_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  tlmlp_pkg::t_word i_x  [FEATURE_COUNT],
    input  tlmlp_pkg::t_word i_w1 [FEATURE_COUNT],
    input  tlmlp_pkg::t_word i_b1,
    input  tlmlp_pkg::t_word i_w2,
    output tlmlp_pkg::t_acc  o_term
);
    import tlmlp_pkg::*;

    localparam int TREE_LVLS = $clog2(FEATURE_COUNT + 1);
    localparam int LEAVES    = 1 << TREE_LVLS;

    t_acc  w_leaf [LEAVES];
    t_acc  r_node [1:2*LEAVES-1];   // heap order: root at 1, leaves at LEAVES..
    t_word r_w2   [TREE_LVLS+1];    // w2 follows the sum down the tree
    t_acc  r_term;
    t_word w_sum_word;
    t_word w_hid;

    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < FEATURE_COUNT) begin : g_prod
            assign w_leaf[k] = mac_term(to_acc(i_w1[k], FRAC_BITS, ACC_FRAC_BITS),
                                        to_acc(i_x[k], FRAC_BITS, ACC_FRAC_BITS),
                                        ACC_FRAC_BITS);
        end else if (k == FEATURE_COUNT) begin : g_bias
            assign w_leaf[k] = to_acc(i_b1, FRAC_BITS, ACC_FRAC_BITS);
        end else begin : g_pad
            assign w_leaf[k] = '0;
        end
    end

    always_comb begin
        w_sum_word = to_word(r_node[1], FRAC_BITS, ACC_FRAC_BITS);
        w_hid      = (w_sum_word > 0) ? w_sum_word : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LEAVES; k++) begin
                r_node[LEAVES+k] <= w_leaf[k];
            end
            for (int i = 1; i < LEAVES; i++) begin
                r_node[i] <= r_node[2*i] + r_node[2*i+1];
            end
            r_w2[0] <= i_w2;
            for (int j = 1; j <= TREE_LVLS; j++) begin
                r_w2[j] <= r_w2[j-1];
            end
            r_term <= mac_term(to_acc(r_w2[TREE_LVLS], FRAC_BITS, ACC_FRAC_BITS),
                               to_acc(w_hid, FRAC_BITS, ACC_FRAC_BITS),
                               ACC_FRAC_BITS);
        end
    end

    assign o_term = r_term;

endmodule

/* sv/tlmlp_merge.sv */
// ============================================================================
// tlmlp_merge - output neuron
// Registered adder tree over the lane terms and the layer-2 bias,
// narrowed to the word format.
// ============================================================================
module tlmlp_merge #(
    parameter int HIDDEN_NEURONS = tlmlp_pkg::DEF_HIDDEN_NEURONS,
    parameter int FRAC_BITS      = tlmlp_pkg::DEF_FRAC_BITS,
    parameter int ACC_FRAC_BITS  = tlmlp_pkg::DEF_ACC_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  tlmlp_pkg::t_acc  i_term [HIDDEN_NEURONS],
    input  tlmlp_pkg::t_word i_b2,
    output tlmlp_pkg::t_word o_result
);
    import tlmlp_pkg::*;

    localparam int TREE_LVLS = $clog2(HIDDEN_NEURONS + 1);
    localparam int LEAVES    = 1 << TREE_LVLS;

    t_acc w_node [1:2*LEAVES-1];   // inner nodes registered, leaves are inputs
    t_acc r_node [1:LEAVES-1];

    for (genvar i = 1; i < LEAVES; i++) begin : g_inner
        assign w_node[i] = r_node[i];
    end

    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < HIDDEN_NEURONS) begin : g_term
            assign w_node[LEAVES+k] = i_term[k];
        end else if (k == HIDDEN_NEURONS) begin : g_bias
            assign w_node[LEAVES+k] = to_acc(i_b2, FRAC_BITS, ACC_FRAC_BITS);
        end else begin : g_pad
            assign w_node[LEAVES+k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 1; i < LEAVES; i++) begin
                r_node[i] <= w_node[2*i] + w_node[2*i+1];
            end
        end
    end

    assign o_result = to_word(r_node[1], FRAC_BITS, ACC_FRAC_BITS);

endmodule

/* sv/two_layer_mlp_inference_top.sv */
// ============================================================================
// two_layer_mlp_inference_top - pipelined two-layer perceptron
// Parallel hidden-neuron lanes, an output merge tree and a skid-buffered
// result stream.
// ============================================================================
// Usage:
//   s_axis carries one word per handshake. tuser holds the opcode: skip, run
//   an inference on the features in tdata, or write one weight word at
//   weight_addr. Skip and write words never produce a result; a write is
//   visible to any run word accepted after it, and addresses past the
//   layer-2 bias are dropped.
//   m_axis returns one word per run word, in order: {gate_out, result}.
//   Throughput: one word per clock while the skid entry is empty. Every
//   hidden neuron has its own lane of FEATURE_COUNT + 1 multipliers, so
//   nothing is shared across words. A run word passes from the accept
//   edge to the edge that loads m_axis through the input register, the
//   lane product and tree levels, the ReLU/layer-2 product stage and the
//   merge tree levels.
//   Reset (synchronous, active low) zeroes every weight and bias and
//   empties the pipeline and output registers.
//   Stall: the output register plus one skid entry absorb a stalled
//   receiver; s_axis_tready drops only while the skid entry is full, and
//   the whole pipeline then holds in place.
// ============================================================================
module two_layer_mlp_inference_top #(
    parameter int HIDDEN_NEURONS = tlmlp_pkg::DEF_HIDDEN_NEURONS,
    parameter int FEATURE_COUNT  = tlmlp_pkg::DEF_FEATURE_COUNT,
    parameter int FRAC_BITS      = tlmlp_pkg::DEF_FRAC_BITS,
    parameter int ACC_FRAC_BITS  = tlmlp_pkg::DEF_ACC_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // feature_a..feature_h, gate_in, weight_addr, weight_value (lowest first)
    input  logic [tlmlp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [tlmlp_pkg::OPCODE_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result, gate_out (lowest first)
    output logic [tlmlp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import tlmlp_pkg::*;

    localparam int L1_LVLS    = $clog2(FEATURE_COUNT + 1);
    localparam int L2_LVLS    = $clog2(HIDDEN_NEURONS + 1);
    localparam int LANE_LAT   = L1_LVLS + 2;
    localparam int PIPE_DEPTH = L1_LVLS + L2_LVLS + 3;

    // pipeline advance: everything moves unless the skid entry is occupied
    logic    w_adv;
    logic    w_accept;
    logic    w_run;
    t_wr_req w_wr;

    // input stage and side pipelines
    t_word                 r_feat  [FEATURE_COUNT];
    logic [PIPE_DEPTH-1:0] r_vld;
    t_word                 r_gate  [PIPE_DEPTH];
    t_word                 r_b2_dly [LANE_LAT];

    // weight store outputs
    t_word w_w1 [HIDDEN_NEURONS][FEATURE_COUNT];
    t_word w_b1 [HIDDEN_NEURONS];
    t_word w_w2 [HIDDEN_NEURONS];
    t_word w_b2;

    // lane terms and merged result
    t_acc  w_term [HIDDEN_NEURONS];
    t_word w_result;

    // output register and skid entry
    logic  w_out_free;
    logic  w_last_vld;
    logic  r_out_valid;
    t_word r_out_result;
    t_word r_out_gate;
    logic  r_skid_valid;
    t_word r_skid_result;
    t_word r_skid_gate;

    assign w_adv      = !r_skid_valid;
    assign w_accept   = s_axis_tvalid && w_adv;
    assign w_run      = w_accept && (s_axis_tuser == OP_RUN);
    assign w_last_vld = w_adv && r_vld[PIPE_DEPTH-1];
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_wr.en    = w_accept && (s_axis_tuser == OP_WRITE);
    assign w_wr.addr  = s_axis_tdata[WADDR_LSB +: WADDR_W];
    assign w_wr.value = s_axis_tdata[WVALUE_LSB +: WORD_W];

    tlmlp_wstore #(
        .HIDDEN_NEURONS (HIDDEN_NEURONS),
        .FEATURE_COUNT  (FEATURE_COUNT)
    ) u_wstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_w1    (w_w1),
        .o_b1    (w_b1),
        .o_w2    (w_w2),
        .o_b2    (w_b2)
    );

    // valid bits: only run words travel down the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_run};
        end
    end

    // payload side pipelines; b2 is sampled with the layer-1 weights so a
    // later write cannot reach a word already in flight
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int f = 0; f < FEATURE_COUNT; f++) begin
                r_feat[f] <= s_axis_tdata[f*WORD_W +: WORD_W];
            end
            r_gate[0] <= s_axis_tdata[GATE_LSB +: WORD_W];
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_gate[k] <= r_gate[k-1];
            end
            r_b2_dly[0] <= w_b2;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_b2_dly[k] <= r_b2_dly[k-1];
            end
        end
    end

    // one lane per hidden neuron
    for (genvar h = 0; h < HIDDEN_NEURONS; h++) begin : g_lane
        tlmlp_lane #(
            .FEATURE_COUNT (FEATURE_COUNT),
            .FRAC_BITS     (FRAC_BITS),
            .ACC_FRAC_BITS (ACC_FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_x    (r_feat),
            .i_w1   (w_w1[h]),
            .i_b1   (w_b1[h]),
            .i_w2   (w_w2[h]),
            .o_term (w_term[h])
        );
    end

    tlmlp_merge #(
        .HIDDEN_NEURONS (HIDDEN_NEURONS),
        .FRAC_BITS      (FRAC_BITS),
        .ACC_FRAC_BITS  (ACC_FRAC_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_term   (w_term),
        .i_b2     (r_b2_dly[LANE_LAT-1]),
        .o_result (w_result)
    );

    // output register / skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= w_last_vld;
                end
            end else if (w_last_vld) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_result <= r_skid_result;
                r_out_gate   <= r_skid_gate;
            end else begin
                r_out_result <= w_result;
                r_out_gate   <= r_gate[PIPE_DEPTH-1];
            end
        end else if (w_adv) begin
            r_skid_result <= w_result;
            r_skid_gate   <= r_gate[PIPE_DEPTH-1];
        end
    end

    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_gate, r_out_result};

    // skid entry fills only behind a stalled output word
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid filled while output register was free");

    // skid entry never holds a word while the output register is empty
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> m_axis_tvalid)
        else $error("skid occupied with empty output register");

    // weight writes never enter the inference pipeline
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE)) |=> !r_vld[0])
        else $error("weight write entered the pipeline");

endmodule

/* tb/two_layer_mlp_inference_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// two_layer_mlp_inference_checker - stream monitor and inference predictor
// Watches both stream channels of the perceptron block. It keeps its own copy
// of the weight store, works out the expected word for every run word
// accepted, and compares each result word field by field, oldest first.
// ============================================================================
module two_layer_mlp_inference_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [tlmlp_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [tlmlp_pkg::OPCODE_W-1:0]  i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [tlmlp_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import tlmlp_pkg::*;

    localparam int HID      = DEF_HIDDEN_NEURONS;
    localparam int FEAT     = DEF_FEATURE_COUNT;
    localparam int FRAC     = DEF_FRAC_BITS;
    localparam int ACC_FRAC = DEF_ACC_FRAC_BITS;

    // flat weight store, same layout as the block's address map
    localparam int L1B_BASE    = HID * FEAT;
    localparam int L2W_BASE    = L1B_BASE + HID;
    localparam int L2B_ADDR    = L2W_BASE + HID;
    localparam int STORE_DEPTH = L2B_ADDR + 1;

    typedef struct {
        t_word result;
        t_word gate;
    } t_mlp_out;

    t_word    weight_mem [STORE_DEPTH];
    t_mlp_out result_q [$];
    int       fails;

    function automatic t_acc word_to_acc(input t_word w);
        longint v;
        v = longint'(w);
        if (ACC_FRAC >= FRAC) begin
            v = v <<< (ACC_FRAC - FRAC);
        end else begin
            v = v >>> (FRAC - ACC_FRAC);
        end
        return t_acc'(v[ACC_W-1:0]);
    endfunction

    // floor to the word fraction, then keep the low 16 bits
    function automatic t_word acc_to_word(input t_acc a);
        longint v;
        v = longint'(a);
        if (ACC_FRAC >= FRAC) begin
            v = v >>> (ACC_FRAC - FRAC);
        end else begin
            v = v <<< (FRAC - ACC_FRAC);
        end
        return t_word'(v[WORD_W-1:0]);
    endfunction

    // sum + wa * wb, product floored back to the accumulator fraction
    function automatic t_acc mul_add(input t_acc sum, input t_word wa, input t_word wb);
        longint p;
        longint s;
        p = longint'(word_to_acc(wa)) * longint'(word_to_acc(wb));
        p = p >>> ACC_FRAC;
        s = longint'(sum) + p;
        return t_acc'(s[ACC_W-1:0]);
    endfunction

    function automatic t_word infer_result(input logic [S_TDATA_W-1:0] data);
        t_acc  out_sum;
        t_acc  hid_sum;
        t_word hid;
        out_sum = word_to_acc(weight_mem[L2B_ADDR]);
        for (int h = 0; h < HID; h++) begin
            hid_sum = word_to_acc(weight_mem[L1B_BASE + h]);
            for (int f = 0; f < FEAT; f++) begin
                hid_sum = mul_add(hid_sum, weight_mem[h * FEAT + f],
                                  t_word'(data[f * WORD_W +: WORD_W]));
            end
            hid = acc_to_word(hid_sum);
            if (hid < 0) begin
                hid = '0;   // ReLU
            end
            out_sum = mul_add(out_sum, weight_mem[L2W_BASE + h], hid);
        end
        return acc_to_word(out_sum);
    endfunction

    always @(posedge i_clk) begin
        t_mlp_out           exp_word;
        t_word              act_result;
        t_word              act_gate;
        logic [WADDR_W-1:0] waddr;
        if (!i_rst_n) begin
            foreach (weight_mem[i]) weight_mem[i] = '0;
            result_q.delete();
            fails = 0;
        end else begin
            // result side first: a word can never answer one accepted this edge
            if (i_m_tvalid && i_m_tready) begin
                act_result = t_word'(i_m_tdata[0 +: WORD_W]);
                act_gate   = t_word'(i_m_tdata[WORD_W +: WORD_W]);
                if (result_q.size() == 0) begin
                    $error("unexpected result word: result %0d gate_out %0d",
                           act_result, act_gate);
                    fails++;
                end else begin
                    exp_word = result_q.pop_front();
                    if (act_result !== exp_word.result) begin
                        $error("result: expected %0d, actual %0d",
                               exp_word.result, act_result);
                        fails++;
                    end
                    if (act_gate !== exp_word.gate) begin
                        $error("gate_out: expected %0d, actual %0d",
                               exp_word.gate, act_gate);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_WRITE) begin
                    waddr = i_s_tdata[WADDR_LSB +: WADDR_W];
                    if (waddr < STORE_DEPTH) begin
                        weight_mem[waddr] = t_word'(i_s_tdata[WVALUE_LSB +: WORD_W]);
                    end
                end else if (i_s_tuser == OP_RUN) begin
                    exp_word.result = infer_result(i_s_tdata);
                    exp_word.gate   = t_word'(i_s_tdata[GATE_LSB +: WORD_W]);
                    result_q.push_back(exp_word);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_q.size();
    end

endmodule

/* tb/two_layer_mlp_inference_top_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// two_layer_mlp_inference_top_tb - stimulus and verdict for the perceptron
// Drives weight writes, run words, skips and the unused opcode into the
// block, first a directed set around the extremes and overflow, then four
// random phases with different sender idling and receiver stalling. The
// checker beside the block predicts and compares every result word.
// ============================================================================
module two_layer_mlp_inference_top_tb;
    import tlmlp_pkg::*;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          WORDS_PER_PHASE = 135;
    localparam int          TAIL_CYCLES     = 40;   // idle margin past the pipeline latency
    localparam logic [1:0]  OP_RESERVED     = 2'd3; // unused code, behaves as skip

    // store addresses used by the directed part
    localparam int ADDR_L1B0 = DEF_HIDDEN_NEURONS * DEF_FEATURE_COUNT;
    localparam int ADDR_L2W0 = ADDR_L1B0 + DEF_HIDDEN_NEURONS;
    localparam int ADDR_L2B  = ADDR_L2W0 + DEF_HIDDEN_NEURONS;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [OPCODE_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    two_layer_mlp_inference_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // feature_a..h, gate_in, weight_addr, weight_value
        .s_axis_tuser  (s_axis_tuser),   // opcode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // result, gate_out
    );

    two_layer_mlp_inference_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random backpressure at the current stall rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // half full-range, half small magnitudes so ReLU sees both signs without
    // every sum wrapping
    function automatic t_word rand_word();
        if ($urandom_range(1) == 1) begin
            return t_word'($urandom);
        end
        return t_word'(int'($urandom_range(2047)) - 1024);
    endfunction

    // run word with every feature set to one value
    function automatic logic [S_TDATA_W-1:0] run_data(input t_word fill, input t_word gate);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        for (int f = 0; f < MAX_FEATURES; f++) d[f * WORD_W +: WORD_W] = fill;
        d[GATE_LSB +: WORD_W] = gate;
        return d;
    endfunction

    function automatic logic [S_TDATA_W-1:0] write_data(input int addr, input t_word value);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[WADDR_LSB +: WADDR_W]   = addr[WADDR_W-1:0];
        d[WVALUE_LSB +: WORD_W]   = value;
        return d;
    endfunction

    // holds one word on s_axis until it is taken; tvalid stays high into the
    // next word unless the sender decides to idle
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [S_TDATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        logic [S_TDATA_W-1:0] d;
        logic [OPCODE_W-1:0]  op;
        int                   r;
        int                   addr;
        d = '0;
        for (int f = 0; f < MAX_FEATURES; f++) d[f * WORD_W +: WORD_W] = rand_word();
        d[GATE_LSB +: WORD_W] = t_word'($urandom);
        // mostly live store addresses, sometimes past the layer-2 bias
        addr = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(ADDR_L2B);
        d[WADDR_LSB +: WADDR_W] = addr[WADDR_W-1:0];
        d[WVALUE_LSB +: WORD_W] = rand_word();
        r = $urandom_range(99);
        if (r < 50) begin
            op = OP_RUN;
        end else if (r < 85) begin
            op = OP_WRITE;
        end else if (r < 95) begin
            op = OP_SKIP;
        end else begin
            op = OP_RESERVED;
        end
        send_word(op, d);
    endtask

    // sender holds off until the checker has seen every expected word
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SKIP;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // empty store: results are zero, gate passes through at its extremes
        send_word(OP_RUN, run_data(16'sh0000, 16'sh7fff));
        send_word(OP_RUN, run_data(16'sh7fff, 16'sh8000));
        // hidden neuron 0 at full scale to force accumulator wrap
        for (int f = 0; f < DEF_FEATURE_COUNT; f++) begin
            send_word(OP_WRITE, write_data(f, 16'sh7fff));
        end
        send_word(OP_WRITE, write_data(ADDR_L1B0, 16'sh7fff));
        send_word(OP_WRITE, write_data(ADDR_L2W0, 16'sh7fff));
        send_word(OP_WRITE, write_data(ADDR_L2B, 16'sh8000));
        send_word(OP_WRITE, write_data(ADDR_L2W0 - 1, 16'shffff));  // last layer-1 bias
        // addresses past the store are dropped
        send_word(OP_WRITE, write_data(ADDR_L2B + 1, 16'sh1234));
        send_word(OP_WRITE, write_data(255, 16'sh7fff));
        send_word(OP_RUN, run_data(16'sh7fff, 16'sh0001));
        send_word(OP_RUN, run_data(16'sh8000, 16'shffff));
        send_word(OP_RUN, run_data(16'sh0001, 16'sh1234));
        send_word(OP_RUN, run_data(16'shffff, 16'sh8000));
        // skip and the unused opcode carry write-shaped data that must not land
        send_word(OP_SKIP, write_data(0, 16'sh1111) | run_data(16'sh5555, 16'sh2222));
        send_word(OP_RESERVED, write_data(0, 16'sh1111));
        send_word(OP_RUN, run_data(16'sh0100, 16'sh7fff));
        drain();

        // ---- random phases: none, sender idle, receiver stall, both ----
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 68; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 68; end
                default: begin send_idle_pct = 32; stall_pct <= 32; end
            endcase
            repeat (WORDS_PER_PHASE) send_random_word();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* two_layer_mlp_inference_top.f */
sv/tlmlp_pkg.sv
sv/tlmlp_wstore.sv
sv/tlmlp_lane.sv
sv/tlmlp_merge.sv
sv/two_layer_mlp_inference_top.sv
tb/two_layer_mlp_inference_checker.sv
tb/two_layer_mlp_inference_top_tb.sv
